// File: design/ids_pkg.sv
// Package for the image difference statistics unit.
// Holds the shared widths, defaults, flag struct and back-end state type.
// No dependencies.
`default_nettype none

package ids_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned PIXEL_WIDTH_DEF = 32;
  localparam int unsigned MAX_PIXELS_DEF  = 16777216;

  // Row length register
  localparam int unsigned ROW_LEN_W     = 13;
  localparam int unsigned COL_W         = 12;
  localparam int unsigned MAX_ROW_LEN   = 4096;
  localparam int unsigned ROW_LEN_RESET = 1;

  // Accumulators and ratio
  localparam int unsigned ACC_W         = 64;
  localparam int unsigned REL_FRAC_BITS = 17;
  localparam int unsigned REL_W         = REL_FRAC_BITS + 1;
  localparam int unsigned REL_ONE       = 1 << REL_FRAC_BITS;
  localparam int unsigned STEP_W        = $clog2(REL_FRAC_BITS);

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic nonzero;
    logic row_end;
    logic last;
  } item_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } back_state_t;

endpackage

`default_nettype wire

// File: design/image_difference_statistics_unit.sv
// Image difference statistics unit, top level. Pairs with both pixels nonzero
// go through a bit-per-cycle restoring divider for the relative difference in
// the back end, which takes no new pair until the last one has been written to
// its output register.
// Reset (rst_n, synchronous, active low) clears the sums, the count, the column
// counter and the queue, and sets the row length to one.
`default_nettype none

module image_difference_statistics_unit #(
  parameter int unsigned PIXEL_WIDTH = ids_pkg::PIXEL_WIDTH_DEF,
  parameter int unsigned MAX_PIXELS  = ids_pkg::MAX_PIXELS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Configuration: row length, written whenever cfg_wr_en is high
  input  wire                                   cfg_wr_en,
  input  wire  [ids_pkg::ROW_LEN_W-1:0]         cfg_wr_data,
  // Input channel: one pixel pair per transaction
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  signed [PIXEL_WIDTH-1:0]         in_pixel_a,
  input  wire  signed [PIXEL_WIDTH-1:0]         in_pixel_b,
  input  wire                                   in_last_pixel,
  // Result channel: one result per pixel pair
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [PIXEL_WIDTH:0]           out_difference,
  output logic [PIXEL_WIDTH-1:0]                out_abs_difference,
  output logic [ids_pkg::REL_W-1:0]             out_rel_difference,
  output logic                                  out_row_end,
  output logic                                  out_totals_valid,
  output logic [ids_pkg::ACC_W-1:0]             out_abs_difference_sum,
  output logic [ids_pkg::ACC_W-1:0]             out_rel_difference_sum,
  output logic [ids_pkg::ACC_W-1:0]             out_mean_abs_sum,
  output logic [$clog2(MAX_PIXELS+1)-1:0]       out_counted_pixels
);

  // Queue entry: signed difference, absolute difference, sum of magnitudes
  // and the classification flags.
  localparam int unsigned ITEM_W = 3 * PIXEL_WIDTH + 5;

  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_data;

  // Front: take pairs at full rate while the queue has room; the column
  // counter and row-end flag live here so they follow input order.
  ids_front #(
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_a    (in_pixel_a),
    .in_pixel_b    (in_pixel_b),
    .in_last_pixel (in_last_pixel),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Queue: decouple the front from the divider and the output stall
  ids_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (ids_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: divide, accumulate with saturation, hold the result register
  ids_back #(
    .PIXEL_WIDTH (PIXEL_WIDTH),
    .MAX_PIXELS  (MAX_PIXELS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (pop_valid),
    .q_ready                (pop_ready),
    .q_data                 (pop_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_difference         (out_difference),
    .out_abs_difference     (out_abs_difference),
    .out_rel_difference     (out_rel_difference),
    .out_row_end            (out_row_end),
    .out_totals_valid       (out_totals_valid),
    .out_abs_difference_sum (out_abs_difference_sum),
    .out_rel_difference_sum (out_rel_difference_sum),
    .out_mean_abs_sum       (out_mean_abs_sum),
    .out_counted_pixels     (out_counted_pixels)
  );

endmodule

`default_nettype wire

// File: design/ids_front.sv
// Front end: accepts pixel pairs, holds the row length register and the
// column counter, and classifies each pair for the back end. Uses ids_pkg.
`default_nettype none

module ids_front #(
  parameter int unsigned PIXEL_WIDTH = ids_pkg::PIXEL_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire  [ids_pkg::ROW_LEN_W-1:0]     cfg_wr_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  signed [PIXEL_WIDTH-1:0]     in_pixel_a,
  input  wire  signed [PIXEL_WIDTH-1:0]     in_pixel_b,
  input  wire                               in_last_pixel,
  output logic                              push_valid,
  input  wire                               push_ready,
  output logic [3*PIXEL_WIDTH+4:0]          push_data
);

  localparam int unsigned P = PIXEL_WIDTH;

  logic [ids_pkg::ROW_LEN_W-1:0] row_len_r, row_len_nxt;
  logic [ids_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [ids_pkg::ROW_LEN_W-1:0] len_eff;
  logic [ids_pkg::ROW_LEN_W-1:0] col_inc;
  logic                          accept;
  logic signed [P:0]             diff;
  logic [P-1:0]                  absd;
  logic [P-1:0]                  mag_a;
  logic [P-1:0]                  mag_b;
  logic [P:0]                    mag_sum;
  ids_pkg::item_flags_t          flags;

  always_comb begin
    accept     = in_valid && push_ready;
    in_ready   = push_ready;
    push_valid = in_valid;

    // Clamp the row length to 1..MAX_ROW_LEN
    if (row_len_r == '0) begin
      len_eff = ids_pkg::ROW_LEN_W'(1);
    end else if (row_len_r > ids_pkg::ROW_LEN_W'(ids_pkg::MAX_ROW_LEN)) begin
      len_eff = ids_pkg::ROW_LEN_W'(ids_pkg::MAX_ROW_LEN);
    end else begin
      len_eff = row_len_r;
    end
    col_inc = {1'b0, col_r} + ids_pkg::ROW_LEN_W'(1);

    diff    = $signed({in_pixel_a[P-1], in_pixel_a}) - $signed({in_pixel_b[P-1], in_pixel_b});
    absd    = diff[P] ? P'(-diff) : P'(diff);
    mag_a   = in_pixel_a[P-1] ? P'(-in_pixel_a) : P'(in_pixel_a);
    mag_b   = in_pixel_b[P-1] ? P'(-in_pixel_b) : P'(in_pixel_b);
    mag_sum = {1'b0, mag_a} + {1'b0, mag_b};

    flags.nonzero = (in_pixel_a != '0) && (in_pixel_b != '0);
    flags.row_end = (col_inc >= len_eff) || in_last_pixel;
    flags.last    = in_last_pixel;

    push_data = {diff, absd, mag_sum, flags};

    row_len_nxt = cfg_wr_en ? cfg_wr_data : row_len_r;
    col_nxt     = col_r;
    if (accept) begin
      col_nxt = flags.row_end ? '0 : col_inc[ids_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= ids_pkg::ROW_LEN_W'(ids_pkg::ROW_LEN_RESET);
      col_r     <= '0;
    end else begin
      row_len_r <= row_len_nxt;
      col_r     <= col_nxt;
    end
  end

  a_last_clears_col: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_pixel |=> col_r == '0)
    else $error("column counter not cleared after last pixel");

endmodule

`default_nettype wire

// File: design/ids_queue.sv
// Short queue between front and back end, register based.
// Generic width and depth (depth a power of two). Uses no package items.
`default_nettype none

module ids_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire  [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    push_ready = cnt_r != CNT_W'(DEPTH);
    pop_valid  = cnt_r != '0;
    pop_data   = mem_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH) && (cnt_r == '0 || pop_valid))
    else $error("queue fill level out of range");

endmodule

`default_nettype wire

// File: design/ids_back.sv
// Back end: relative difference divider, saturating accumulators and the
// output register. Uses ids_pkg for widths and the state type.
`default_nettype none

module ids_back #(
  parameter int unsigned PIXEL_WIDTH = ids_pkg::PIXEL_WIDTH_DEF,
  parameter int unsigned MAX_PIXELS  = ids_pkg::MAX_PIXELS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   q_valid,
  output logic                                  q_ready,
  input  wire  [3*PIXEL_WIDTH+4:0]              q_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [PIXEL_WIDTH:0]           out_difference,
  output logic [PIXEL_WIDTH-1:0]                out_abs_difference,
  output logic [ids_pkg::REL_W-1:0]             out_rel_difference,
  output logic                                  out_row_end,
  output logic                                  out_totals_valid,
  output logic [ids_pkg::ACC_W-1:0]             out_abs_difference_sum,
  output logic [ids_pkg::ACC_W-1:0]             out_rel_difference_sum,
  output logic [ids_pkg::ACC_W-1:0]             out_mean_abs_sum,
  output logic [$clog2(MAX_PIXELS+1)-1:0]       out_counted_pixels
);

  localparam int unsigned P      = PIXEL_WIDTH;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned ACC_W  = ids_pkg::ACC_W;
  localparam int unsigned REL_W  = ids_pkg::REL_W;
  localparam int unsigned STEP_W = ids_pkg::STEP_W;

  ids_pkg::back_state_t state_r, state_nxt;

  // Item under work
  logic signed [P:0]     diff_r, diff_nxt;
  logic [P-1:0]          absd_r, absd_nxt;
  logic [P:0]            den_r, den_nxt;
  ids_pkg::item_flags_t  flags_r, flags_nxt;

  // Divider
  logic [P:0]            rem_r, rem_nxt;
  logic [REL_W-1:0]      quo_r, quo_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [P+1:0]          rem_sh;
  logic [P+1:0]          rem_sub;
  logic [P:0]            rem_init_sub;

  // Accumulators
  logic [ACC_W-1:0]      abs_acc_r, abs_acc_nxt;
  logic [ACC_W-1:0]      rel_acc_r, rel_acc_nxt;
  logic [ACC_W-1:0]      mean_acc_r, mean_acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ACC_W:0]        abs_add, rel_add, mean_add;
  logic [ACC_W-1:0]      abs_new, rel_new, mean_new;
  logic [CNT_W-1:0]      cnt_new;

  // Unpacked queue entry
  logic signed [P:0]     q_diff;
  logic [P-1:0]          q_absd;
  logic [P:0]            q_sum;
  ids_pkg::item_flags_t  q_flags;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic signed [P:0]     o_diff_r, o_diff_nxt;
  logic [P-1:0]          o_absd_r, o_absd_nxt;
  logic [REL_W-1:0]      o_rel_r, o_rel_nxt;
  logic                  o_row_end_r, o_row_end_nxt;
  logic                  o_tot_r, o_tot_nxt;
  logic [ACC_W-1:0]      o_abs_sum_r, o_abs_sum_nxt;
  logic [ACC_W-1:0]      o_rel_sum_r, o_rel_sum_nxt;
  logic [ACC_W-1:0]      o_mean_sum_r, o_mean_sum_nxt;
  logic [CNT_W-1:0]      o_cnt_r, o_cnt_nxt;
  logic                  slot_free;

  always_comb begin
    {q_diff, q_absd, q_sum, q_flags} = q_data;
    slot_free = !out_valid_r || out_ready;

    rem_sh       = {rem_r, 1'b0};
    rem_sub      = rem_sh - {1'b0, den_r};
    rem_init_sub = {1'b0, q_absd} - q_sum;

    abs_add  = {1'b0, abs_acc_r} + (ACC_W + 1)'(absd_r);
    rel_add  = {1'b0, rel_acc_r} + (ACC_W + 1)'(quo_r);
    mean_add = {1'b0, mean_acc_r} + (ACC_W + 1)'(den_r[P:1]);
    abs_new  = abs_add[ACC_W] ? '1 : abs_add[ACC_W-1:0];
    rel_new  = rel_add[ACC_W] ? '1 : rel_add[ACC_W-1:0];
    mean_new = mean_add[ACC_W] ? '1 : mean_add[ACC_W-1:0];
    cnt_new  = (flags_r.nonzero && cnt_r != CNT_W'(MAX_PIXELS)) ? cnt_r + CNT_W'(1) : cnt_r;

    state_nxt      = state_r;
    diff_nxt       = diff_r;
    absd_nxt       = absd_r;
    den_nxt        = den_r;
    flags_nxt      = flags_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    abs_acc_nxt    = abs_acc_r;
    rel_acc_nxt    = rel_acc_r;
    mean_acc_nxt   = mean_acc_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_diff_nxt     = o_diff_r;
    o_absd_nxt     = o_absd_r;
    o_rel_nxt      = o_rel_r;
    o_row_end_nxt  = o_row_end_r;
    o_tot_nxt      = o_tot_r;
    o_abs_sum_nxt  = o_abs_sum_r;
    o_rel_sum_nxt  = o_rel_sum_r;
    o_mean_sum_nxt = o_mean_sum_r;
    o_cnt_nxt      = o_cnt_r;
    q_ready        = 1'b0;

    case (state_r)
      ids_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          diff_nxt  = q_diff;
          absd_nxt  = q_absd;
          den_nxt   = q_sum;
          flags_nxt = q_flags;
          step_nxt  = '0;
          if (q_flags.nonzero) begin
            // Integer bit of the quotient first, then the fraction bits
            if ({1'b0, q_absd} >= q_sum) begin
              quo_nxt = REL_W'(1);
              rem_nxt = rem_init_sub;
            end else begin
              quo_nxt = '0;
              rem_nxt = {1'b0, q_absd};
            end
            state_nxt = ids_pkg::ST_DIV;
          end else begin
            quo_nxt   = '0;
            state_nxt = ids_pkg::ST_WRITE;
          end
        end
      end
      ids_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sub[P:0];
          quo_nxt = {quo_r[REL_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[P:0];
          quo_nxt = {quo_r[REL_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ids_pkg::REL_FRAC_BITS - 1)) begin
          state_nxt = ids_pkg::ST_WRITE;
        end
      end
      ids_pkg::ST_WRITE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_diff_nxt    = diff_r;
          o_absd_nxt    = absd_r;
          o_rel_nxt     = quo_r;
          o_row_end_nxt = flags_r.row_end;
          o_tot_nxt     = flags_r.last;
          if (flags_r.last) begin
            // Report the totals including this pixel, then clear
            o_abs_sum_nxt  = abs_new;
            o_rel_sum_nxt  = rel_new;
            o_mean_sum_nxt = mean_new;
            o_cnt_nxt      = cnt_new;
            abs_acc_nxt    = '0;
            rel_acc_nxt    = '0;
            mean_acc_nxt   = '0;
            cnt_nxt        = '0;
          end else begin
            o_abs_sum_nxt  = '0;
            o_rel_sum_nxt  = '0;
            o_mean_sum_nxt = '0;
            o_cnt_nxt      = '0;
            abs_acc_nxt    = abs_new;
            rel_acc_nxt    = rel_new;
            mean_acc_nxt   = mean_new;
            cnt_nxt        = cnt_new;
          end
          state_nxt = ids_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ids_pkg::ST_IDLE;
      end
    endcase

    out_valid              = out_valid_r;
    out_difference         = o_diff_r;
    out_abs_difference     = o_absd_r;
    out_rel_difference     = o_rel_r;
    out_row_end            = o_row_end_r;
    out_totals_valid       = o_tot_r;
    out_abs_difference_sum = o_abs_sum_r;
    out_rel_difference_sum = o_rel_sum_r;
    out_mean_abs_sum       = o_mean_sum_r;
    out_counted_pixels     = o_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ids_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      abs_acc_r   <= '0;
      rel_acc_r   <= '0;
      mean_acc_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      abs_acc_r   <= abs_acc_nxt;
      rel_acc_r   <= rel_acc_nxt;
      mean_acc_r  <= mean_acc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r       <= diff_nxt;
    absd_r       <= absd_nxt;
    den_r        <= den_nxt;
    flags_r      <= flags_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    o_diff_r     <= o_diff_nxt;
    o_absd_r     <= o_absd_nxt;
    o_rel_r      <= o_rel_nxt;
    o_row_end_r  <= o_row_end_nxt;
    o_tot_r      <= o_tot_nxt;
    o_abs_sum_r  <= o_abs_sum_nxt;
    o_rel_sum_r  <= o_rel_sum_nxt;
    o_mean_sum_r <= o_mean_sum_nxt;
    o_cnt_r      <= o_cnt_nxt;
  end

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ids_pkg::ST_DIV && step_r == STEP_W'(ids_pkg::REL_FRAC_BITS - 1)
    |=> state_r == ids_pkg::ST_WRITE)
    else $error("divider did not finish after the last fraction bit");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ids_pkg::ST_WRITE |-> quo_r <= REL_W'(ids_pkg::REL_ONE))
    else $error("relative difference above one");

  a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_tot_r |-> o_abs_sum_r == '0 && o_rel_sum_r == '0 &&
                                o_mean_sum_r == '0 && o_cnt_r == '0)
    else $error("totals shown on a pixel that is not last");

endmodule

`default_nettype wire

// File: verif/ids_checker.sv
`timescale 1ns / 1ps
// Checker for the image difference statistics unit: predicts each result from
// the observed transactions and compares it field by field. Depends on ids_pkg.
module ids_checker (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      cfg_wr_en,
  input  wire  [ids_pkg::ROW_LEN_W-1:0]            cfg_wr_data,
  input  wire                                      in_valid,
  input  wire                                      in_ready,
  input  wire  signed [ids_pkg::PIXEL_WIDTH_DEF-1:0] in_pixel_a,
  input  wire  signed [ids_pkg::PIXEL_WIDTH_DEF-1:0] in_pixel_b,
  input  wire                                      in_last_pixel,
  input  wire                                      out_valid,
  input  wire                                      out_ready,
  input  wire  [ids_pkg::PIXEL_WIDTH_DEF:0]        out_difference,
  input  wire  [ids_pkg::PIXEL_WIDTH_DEF-1:0]      out_abs_difference,
  input  wire  [ids_pkg::REL_W-1:0]                out_rel_difference,
  input  wire                                      out_row_end,
  input  wire                                      out_totals_valid,
  input  wire  [ids_pkg::ACC_W-1:0]                out_abs_difference_sum,
  input  wire  [ids_pkg::ACC_W-1:0]                out_rel_difference_sum,
  input  wire  [ids_pkg::ACC_W-1:0]                out_mean_abs_sum,
  input  wire  [$clog2(ids_pkg::MAX_PIXELS_DEF+1)-1:0] out_counted_pixels,
  output logic [31:0]                              mismatch_count,
  output logic [31:0]                              results_due
);

  localparam int PW    = ids_pkg::PIXEL_WIDTH_DEF;
  localparam int CNT_W = $clog2(ids_pkg::MAX_PIXELS_DEF + 1);
  localparam int ACC_W = ids_pkg::ACC_W;
  localparam int REL_W = ids_pkg::REL_W;

  typedef struct packed {
    logic [PW:0]        difference;
    logic [PW-1:0]      abs_difference;
    logic [REL_W-1:0]   rel_difference;
    logic               row_end;
    logic               totals_valid;
    logic [ACC_W-1:0]   abs_difference_sum;
    logic [ACC_W-1:0]   rel_difference_sum;
    logic [ACC_W-1:0]   mean_abs_sum;
    logic [CNT_W-1:0]   counted_pixels;
  } pixel_stats_t;

  pixel_stats_t                  stats_due[$];
  pixel_stats_t                  head;
  logic [ids_pkg::ROW_LEN_W-1:0] row_length;
  logic [ACC_W-1:0]              abs_acc;
  logic [ACC_W-1:0]              rel_acc;
  logic [ACC_W-1:0]              mean_acc;
  logic [CNT_W-1:0]              pair_count;
  logic [ids_pkg::COL_W-1:0]     column;
  int                            mismatches = 0;

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] inc);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  endfunction

  task automatic note_mismatch(input string field, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected %h, got %h", $time, field, want, got);
  endtask

  // Fold one pixel pair into the running totals and queue its result
  task automatic predict_pixel_stats(input logic signed [PW-1:0] a,
                                     input logic signed [PW-1:0] b,
                                     input logic last);
    logic signed [63:0] sa, sb, diff, absd, ma, mb, msum, rel;
    int                 eff_len;
    logic               ends_row;
    pixel_stats_t       r;
    sa   = 64'(a);
    sb   = 64'(b);
    diff = sa - sb;
    absd = (diff < 0) ? -diff : diff;
    ma   = (sa < 0) ? -sa : sa;
    mb   = (sb < 0) ? -sb : sb;
    msum = ma + mb;
    rel  = 0;
    if (ma != 0 && mb != 0) begin
      // exact mean, so the ratio is 2^17 * |a-b| / (|a|+|b|), truncated
      rel     = (absd << ids_pkg::REL_FRAC_BITS) / msum;
      rel_acc = sat_acc(rel_acc, rel);
      if (pair_count < CNT_W'(ids_pkg::MAX_PIXELS_DEF))
        pair_count = pair_count + 1'b1;
    end
    abs_acc  = sat_acc(abs_acc, absd);
    mean_acc = sat_acc(mean_acc, msum >> 1);

    eff_len = int'(row_length);
    if (eff_len == 0)
      eff_len = 1;
    if (eff_len > int'(ids_pkg::MAX_ROW_LEN))
      eff_len = int'(ids_pkg::MAX_ROW_LEN);
    ends_row = (int'(column) + 1 >= eff_len) || last;
    column   = ends_row ? '0 : column + 1'b1;

    r                = '0;
    r.difference     = diff[PW:0];
    r.abs_difference = absd[PW-1:0];
    r.rel_difference = rel[REL_W-1:0];
    r.row_end        = ends_row;
    r.totals_valid   = last;
    if (last) begin
      r.abs_difference_sum = abs_acc;
      r.rel_difference_sum = rel_acc;
      r.mean_abs_sum       = mean_acc;
      r.counted_pixels     = pair_count;
      abs_acc    = '0;
      rel_acc    = '0;
      mean_acc   = '0;
      pair_count = '0;
      column     = '0;
    end
    stats_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stats_due.delete();
      row_length = ids_pkg::ROW_LEN_W'(ids_pkg::ROW_LEN_RESET);
      abs_acc    = '0;
      rel_acc    = '0;
      mean_acc   = '0;
      pair_count = '0;
      column     = '0;
    end else begin
      if (cfg_wr_en)
        row_length = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          note_mismatch("unexpected result", '0, '0);
        end else begin
          head = stats_due.pop_front();
          if (out_difference !== head.difference)
            note_mismatch("difference", ACC_W'(head.difference),
                          ACC_W'(out_difference));
          if (out_abs_difference !== head.abs_difference)
            note_mismatch("abs_difference", ACC_W'(head.abs_difference),
                          ACC_W'(out_abs_difference));
          if (out_rel_difference !== head.rel_difference)
            note_mismatch("rel_difference", ACC_W'(head.rel_difference),
                          ACC_W'(out_rel_difference));
          if (out_row_end !== head.row_end)
            note_mismatch("row_end", ACC_W'(head.row_end), ACC_W'(out_row_end));
          if (out_totals_valid !== head.totals_valid)
            note_mismatch("totals_valid", ACC_W'(head.totals_valid),
                          ACC_W'(out_totals_valid));
          if (out_abs_difference_sum !== head.abs_difference_sum)
            note_mismatch("abs_difference_sum", head.abs_difference_sum,
                          out_abs_difference_sum);
          if (out_rel_difference_sum !== head.rel_difference_sum)
            note_mismatch("rel_difference_sum", head.rel_difference_sum,
                          out_rel_difference_sum);
          if (out_mean_abs_sum !== head.mean_abs_sum)
            note_mismatch("mean_abs_sum", head.mean_abs_sum, out_mean_abs_sum);
          if (out_counted_pixels !== head.counted_pixels)
            note_mismatch("counted_pixels", ACC_W'(head.counted_pixels),
                          ACC_W'(out_counted_pixels));
        end
      end
      if (in_valid && in_ready)
        predict_pixel_stats(in_pixel_a, in_pixel_b, in_last_pixel);
    end
    results_due    <= stats_due.size();
    mismatch_count <= mismatches;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top of the image difference statistics unit testbench: clock, reset,
// stimulus and verdict. Depends on ids_pkg, ids_checker and the unit itself.
module tb;

  localparam int PW               = ids_pkg::PIXEL_WIDTH_DEF;
  localparam int CNT_W            = $clog2(ids_pkg::MAX_PIXELS_DEF + 1);
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 125;
  localparam int NUM_PHASES       = 9;

  localparam logic signed [PW-1:0] PIX_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PIX_MIN = {1'b1, {(PW-1){1'b0}}};

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [ids_pkg::ROW_LEN_W-1:0]   cfg_wr_data;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [PW-1:0]            in_pixel_a;
  logic signed [PW-1:0]            in_pixel_b;
  logic                            in_last_pixel;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [PW:0]              out_difference;
  logic [PW-1:0]                   out_abs_difference;
  logic [ids_pkg::REL_W-1:0]       out_rel_difference;
  logic                            out_row_end;
  logic                            out_totals_valid;
  logic [ids_pkg::ACC_W-1:0]       out_abs_difference_sum;
  logic [ids_pkg::ACC_W-1:0]       out_rel_difference_sum;
  logic [ids_pkg::ACC_W-1:0]       out_mean_abs_sum;
  logic [CNT_W-1:0]                out_counted_pixels;
  logic [31:0]                     mismatch_count;
  logic [31:0]                     results_due;

  int   cycle_count   = 0;
  bit   sender_quiet   = 1'b0;
  bit   receiver_quiet = 1'b0;
  bit   long_hold_go   = 1'b0;
  // Row lengths per phase: reset value, zero, tiny, the extremes and beyond
  int   row_plan [NUM_PHASES] = '{1, 0, 2, 4096, 8191, 4097, 4095, 5, 37};

  image_difference_statistics_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_pixel_a             (in_pixel_a),
    .in_pixel_b             (in_pixel_b),
    .in_last_pixel          (in_last_pixel),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_difference         (out_difference),
    .out_abs_difference     (out_abs_difference),
    .out_rel_difference     (out_rel_difference),
    .out_row_end            (out_row_end),
    .out_totals_valid       (out_totals_valid),
    .out_abs_difference_sum (out_abs_difference_sum),
    .out_rel_difference_sum (out_rel_difference_sum),
    .out_mean_abs_sum       (out_mean_abs_sum),
    .out_counted_pixels     (out_counted_pixels)
  );

  ids_checker ids_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_pixel_a             (in_pixel_a),
    .in_pixel_b             (in_pixel_b),
    .in_last_pixel          (in_last_pixel),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_difference         (out_difference),
    .out_abs_difference     (out_abs_difference),
    .out_rel_difference     (out_rel_difference),
    .out_row_end            (out_row_end),
    .out_totals_valid       (out_totals_valid),
    .out_abs_difference_sum (out_abs_difference_sum),
    .out_rel_difference_sum (out_rel_difference_sum),
    .out_mean_abs_sum       (out_mean_abs_sum),
    .out_counted_pixels     (out_counted_pixels),
    .mismatch_count         (mismatch_count),
    .results_due            (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: abandon the run if the block wedges
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("image_difference_statistics_unit regression: fail");
      $finish;
    end
  end

  function automatic logic signed [PW-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return PIX_MIN;
      1:       return PIX_MAX;
      2:       return -1;
      3:       return 1;
      4:       return 0;
      default: return 32'sh0001_0000;   // 1.0 in Q16.16
    endcase
  endfunction

  // Offer one pixel pair after a random gap and hold it until the transaction
  // completes; valid stays high when the next pair follows with no gap.
  task automatic send_pixel(input logic signed [PW-1:0] a, input logic signed [PW-1:0] b,
                            input logic last);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_a    <= a;
    in_pixel_b    <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Write the row length only once the block has gone quiet
  task automatic set_row_length(input int value);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= value[ids_pkg::ROW_LEN_W-1:0];
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver: randomly stall each result, with one long hold-off on
  // request so the queue fills up and in_ready drops.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      stall = receiver_quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    logic signed [PW-1:0] a, b;
    int                   img_len, sent, setting;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_pixel_a    = '0;
    in_pixel_b    = '0;
    in_last_pixel = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero pixels, full-scale extremes, sign flips, equal pixels,
    // last pixel mid-row and on the first pixel of an image. Rows of three.
    set_row_length(3);
    send_pixel(0, 0, 1'b0);
    send_pixel(0, 5, 1'b0);
    send_pixel(7, 0, 1'b0);
    send_pixel(PIX_MAX, PIX_MIN, 1'b0);
    send_pixel(PIX_MIN, PIX_MAX, 1'b0);
    send_pixel(PIX_MIN, PIX_MIN, 1'b0);
    send_pixel(PIX_MAX, PIX_MAX, 1'b1);
    send_pixel(1, -1, 1'b0);
    send_pixel(-1, 1, 1'b0);
    send_pixel(1, PIX_MAX, 1'b0);
    send_pixel(PIX_MIN, 1, 1'b0);
    send_pixel(32'sh0001_0000, 32'sh0000_8000, 1'b1);
    send_pixel(3, 3, 1'b1);
    send_pixel(-5, 5, 1'b0);
    send_pixel(PIX_MIN, 0, 1'b0);
    send_pixel(0, PIX_MAX, 1'b0);
    send_pixel(PIX_MIN, -1, 1'b0);
    send_pixel(2, 3, 1'b0);
    send_pixel(-7, -3, 1'b1);
    wait_for_results();

    // Random images, one row length per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      setting = (phase == 7) ? $urandom_range(3, 64) : row_plan[phase];
      set_row_length(setting);
      sender_quiet   = (phase % 3 == 1);
      receiver_quiet = (phase % 4 == 3);
      if (phase == 2) begin
        // back-to-back pairs against a stalled receiver
        sender_quiet = 1'b1;
        long_hold_go = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 300)
                                              : $urandom_range(1, 24);
        // cut the last image of the phase short to keep the item count
        if (img_len > PHASE_ITEMS - sent)
          img_len = PHASE_ITEMS - sent;
        for (int i = 0; i < img_len; i++) begin
          a = $urandom;
          b = $urandom;
          case ($urandom_range(0, 9))
            0: a = '0;
            1: b = '0;
            2: begin
              a = pick_extreme();
              b = pick_extreme();
            end
            3: b = a;
            4: b = -a;
            5: b = a + PW'($urandom_range(0, 64)) - 32;
            6: begin
              a = a >>> 12;
              b = b >>> 12;
            end
            default: ;
          endcase
          send_pixel(a, b, i == img_len - 1);
        end
        sent += img_len;
        // now and then, pause the sender until the pipeline is empty
        if ($urandom_range(0, 15) == 0)
          wait_for_results();
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("image_difference_statistics_unit regression: pass");
    else
      $display("image_difference_statistics_unit regression: fail");
    $finish;
  end

endmodule

// File: files.f
design/ids_pkg.sv
design/ids_front.sv
design/ids_queue.sv
design/ids_back.sv
design/image_difference_statistics_unit.sv
verif/ids_checker.sv
verif/tb.sv
